// ===== sv/fcu_pkg.sv =====
package fcu_pkg;

  // Fixed field counts and widths
  localparam int MAX_EXISTING = 5;
  localparam int MAX_NEW      = 3;
  localparam int DIST_W       = 15;
  localparam int WEIGHT_W     = 16;
  localparam int SHARE_W      = 9;
  localparam int MIN_W        = 17;
  localparam int SUM_W        = 48;
  localparam int ADD_W        = 24;
  localparam int PCT_W        = 15;
  localparam int NUM_W        = 63;
  localparam int QUO_W        = 15;
  localparam int ITER_W       = 4;

  // Arithmetic constants
  localparam logic [MIN_W-1:0]   SENTINEL_KM = 17'd100000;
  localparam logic [SHARE_W-1:0] FULL_SHARE  = 9'd256;
  localparam logic [PCT_W-1:0]   PCT_SCALE   = 15'd25600;
  localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};

  // Configuration register indexes
  localparam logic [1:0] CFG_EXISTING_COUNT = 2'd0;
  localparam logic [1:0] CFG_NEW_COUNT      = 2'd1;
  localparam logic [1:0] CFG_TIE_SHARE      = 2'd2;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [DIST_W-1:0]   existing_dist_0;
    logic [DIST_W-1:0]   existing_dist_1;
    logic [DIST_W-1:0]   existing_dist_2;
    logic [DIST_W-1:0]   existing_dist_3;
    logic [DIST_W-1:0]   existing_dist_4;
    logic [DIST_W-1:0]   new_dist_0;
    logic [DIST_W-1:0]   new_dist_1;
    logic [DIST_W-1:0]   new_dist_2;
    logic                last_point;
  } fcu_in_t;

  typedef struct packed {
    logic [PCT_W-1:0] utility_percent;
    logic             saturated;
  } fcu_out_t;

  // One classified point waiting for the accumulator
  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [ADD_W-1:0]    cap_add;
    logic                last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

// ===== sv/fcu_front.sv =====
module fcu_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [8:0]       cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  fcu_pkg::fcu_in_t in_data,
  input  fcu_pkg::q_stat_t q_stat,
  output logic             push,
  output fcu_pkg::q_entry_t push_data
);
  import fcu_pkg::*;

  logic [2:0]         existing_count;
  logic [1:0]         new_count;
  logic [SHARE_W-1:0] tie_share;

  logic [DIST_W-1:0]  e_dist [MAX_EXISTING];
  logic [DIST_W-1:0]  n_dist [MAX_NEW];
  logic [2:0]         n_e;
  logic [1:0]         n_n;
  logic [MIN_W-1:0]   best_e;
  logic [MIN_W-1:0]   best_n;
  logic [SHARE_W-1:0] share;
  logic [ADD_W:0]     tie_prod;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      existing_count <= 3'd5;
      new_count      <= 2'd3;
      tie_share      <= 9'd77;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EXISTING_COUNT: existing_count <= cfg_data[2:0];
        CFG_NEW_COUNT:      new_count      <= cfg_data[1:0];
        CFG_TIE_SHARE:      tie_share      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign e_dist[0] = in_data.existing_dist_0;
  assign e_dist[1] = in_data.existing_dist_1;
  assign e_dist[2] = in_data.existing_dist_2;
  assign e_dist[3] = in_data.existing_dist_3;
  assign e_dist[4] = in_data.existing_dist_4;
  assign n_dist[0] = in_data.new_dist_0;
  assign n_dist[1] = in_data.new_dist_1;
  assign n_dist[2] = in_data.new_dist_2;

  // Clamp counts and tie share
  assign n_e   = (int'(existing_count) > MAX_EXISTING) ? 3'(MAX_EXISTING) : existing_count;
  assign n_n   = (int'(new_count) > MAX_NEW) ? 2'(MAX_NEW) : new_count;
  assign share = (tie_share > FULL_SHARE) ? FULL_SHARE : tie_share;

  // Minimum over the enabled entries of each group
  always_comb begin
    best_e = SENTINEL_KM;
    for (int j = 0; j < MAX_EXISTING; j++) begin
      if (j < int'(n_e) && {2'b00, e_dist[j]} < best_e) begin
        best_e = {2'b00, e_dist[j]};
      end
    end
    best_n = SENTINEL_KM;
    for (int j = 0; j < MAX_NEW; j++) begin
      if (j < int'(n_n) && {2'b00, n_dist[j]} < best_n) begin
        best_n = {2'b00, n_dist[j]};
      end
    end
  end

  // Classify: full capture, tie share, or nothing
  assign tie_prod = {9'd0, in_data.weight} * {16'd0, share};

  always_comb begin
    push_data.weight = in_data.weight;
    push_data.last   = in_data.last_point;
    if (best_n < best_e) begin
      push_data.cap_add = {in_data.weight, 8'd0};
    end else if (best_n == best_e) begin
      push_data.cap_add = tie_prod[ADD_W-1:0];
    end else begin
      push_data.cap_add = '0;
    end
  end

  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

endmodule

// ===== sv/fcu_queue.sv =====
module fcu_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fcu_pkg::q_entry_t push_data,
  input  logic              pop,
  output fcu_pkg::q_entry_t rd_data,
  output fcu_pkg::q_stat_t  q_stat
);
  import fcu_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Write the incoming entry
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign rd_data      = slots[rd_ptr];
  assign q_stat.full  = (count == CNT_W'(DEPTH));
  assign q_stat.empty = (count == '0);

endmodule

// ===== sv/fcu_back.sv =====
module fcu_back (
  input  logic              clk,
  input  logic              rst,
  input  fcu_pkg::q_entry_t rd_data,
  input  fcu_pkg::q_stat_t  q_stat,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output fcu_pkg::fcu_out_t out_data
);
  import fcu_pkg::*;

  back_state_t        state, state_next;
  logic [SUM_W-1:0]   captured_sum, captured_sum_next;
  logic [SUM_W-1:0]   total_sum, total_sum_next;
  logic               overflow_seen, overflow_seen_next;
  logic [NUM_W-1:0]   num, num_next;
  logic [NUM_W-2:0]   den_sh, den_sh_next;
  logic [QUO_W-1:0]   quo, quo_next;
  logic [ITER_W-1:0]  iter, iter_next;
  logic               zero_total, zero_total_next;
  logic               sat_hold, sat_hold_next;
  logic               out_valid_next;
  fcu_out_t           out_data_next;

  logic [SUM_W:0]     tot_s;
  logic [SUM_W:0]     cap_s;
  logic               ge;
  logic [NUM_W-1:0]   cap_wide;
  logic [PCT_W-1:0]   util;
  logic               load_out;

  // Saturating sums for the entry at the head of the queue
  assign tot_s = {1'b0, total_sum} + {25'd0, rd_data.weight, 8'd0};
  assign cap_s = {1'b0, captured_sum} + {25'd0, rd_data.cap_add};

  // Divider step and numerator scale (x25600 = x16384 + x8192 + x1024)
  assign ge       = num >= {1'b0, den_sh};
  assign cap_wide = NUM_W'(captured_sum);
  assign util     = zero_total ? '0 : ((quo > PCT_SCALE) ? PCT_SCALE : quo);
  assign load_out = (state == BK_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_ACC;
      captured_sum  <= '0;
      total_sum     <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      captured_sum  <= captured_sum_next;
      total_sum     <= total_sum_next;
      overflow_seen <= overflow_seen_next;
      out_valid     <= out_valid_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    num        <= num_next;
    den_sh     <= den_sh_next;
    quo        <= quo_next;
    iter       <= iter_next;
    zero_total <= zero_total_next;
    sat_hold   <= sat_hold_next;
    out_data   <= out_data_next;
  end

  always_comb begin
    state_next         = state;
    captured_sum_next  = captured_sum;
    total_sum_next     = total_sum;
    overflow_seen_next = overflow_seen;
    num_next           = num;
    den_sh_next        = den_sh;
    quo_next           = quo;
    iter_next          = iter;
    zero_total_next    = zero_total;
    sat_hold_next      = sat_hold;
    out_data_next      = out_data;
    out_valid_next     = out_valid && out_stall;
    pop                = 1'b0;

    unique case (state)
      BK_ACC: begin
        // Accumulate one point per cycle while the queue is not empty
        if (!q_stat.empty) begin
          pop = 1'b1;
          total_sum_next   = tot_s[SUM_W] ? SUM_MAX : tot_s[SUM_W-1:0];
          captured_sum_next = cap_s[SUM_W] ? SUM_MAX : cap_s[SUM_W-1:0];
          overflow_seen_next = overflow_seen || tot_s[SUM_W] || cap_s[SUM_W];
          if (rd_data.last) begin
            state_next = BK_PREP;
          end
        end
      end
      BK_PREP: begin
        // Load divider and start a new evaluation
        num_next           = (cap_wide << 14) + (cap_wide << 13) + (cap_wide << 10);
        den_sh_next        = {total_sum, 14'd0};
        zero_total_next    = (total_sum == '0);
        sat_hold_next      = overflow_seen;
        quo_next           = '0;
        iter_next          = '0;
        captured_sum_next  = '0;
        total_sum_next     = '0;
        overflow_seen_next = 1'b0;
        state_next         = BK_DIV;
      end
      BK_DIV: begin
        // One quotient bit per cycle, MSB first
        if (ge) begin
          num_next = num - {1'b0, den_sh};
        end
        quo_next    = {quo[QUO_W-2:0], ge};
        den_sh_next = den_sh >> 1;
        iter_next   = iter + 1'b1;
        if (iter == ITER_W'(QUO_W - 1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        // Hand the result to the output register once it is free
        if (load_out) begin
          out_valid_next                = 1'b1;
          out_data_next.utility_percent = util;
          out_data_next.saturated       = sat_hold;
          state_next                    = BK_ACC;
        end
      end
      default: state_next = BK_ACC;
    endcase
  end

endmodule

// ===== sv/facility_capture_utility_top.sv =====
// Competitive facility capture objective over a stream of demand points.
// Input channel (in_valid / in_stall / in_data): one demand point per transfer,
// carrying its weight, distances to existing and new facilities, and last_point.
// Output channel (out_valid / out_stall / out_data): one result per evaluation,
// issued for the point that carries last_point.
// Configuration: cfg_write with cfg_index / cfg_data sets existing_count,
// new_count and tie_share; write only while the block is idle.
// Points that are not last pass through the accumulator while the queue holds
// them, so a steady stream is accepted at one point per cycle while in_stall is
// low. A last point holds the accumulator for the numerator scale plus a 15-step
// restoring divide, after which the output register takes the result.
// The queue between classifier and accumulator (QUEUE_DEPTH entries) absorbs
// points during a divide; in_stall rises only when it is full.
// When the receiver stalls, the result holds in the output register; one more
// finished result waits in the accumulator and further points fill the queue.
// Reset (rst, synchronous) restores counts 5 and 3, tie share 77, and clears
// the sums, the queue and the output valid.
module facility_capture_utility_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  fcu_pkg::fcu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output fcu_pkg::fcu_out_t out_data
);
  import fcu_pkg::*;

  q_stat_t  q_stat;
  q_entry_t push_data;
  q_entry_t rd_data;
  logic     push;
  logic     pop;

  fcu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  fcu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (rd_data),
    .q_stat    (q_stat)
  );

  fcu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_data   (rd_data),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  // Result never exceeds full capture
  a_util_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.utility_percent <= PCT_SCALE)
    else $error("utility above 100 percent");

  // Accumulator never drains an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // Accumulator stops taking points while the divide runs
  a_hold_after_last: assert property (@(posedge clk) disable iff (rst)
    (pop && rd_data.last) |=> !pop)
    else $error("pop right after last point");
`endif

endmodule
